/* rtl/clock_synth_divider_planner_core_defines.svh */
// -----------------------------------------------------------------------------
// Clock synthesizer divider planner - assertion macros
// Assertion helpers. They expand to nothing when SYNTHESIS is defined.
// -----------------------------------------------------------------------------
`ifndef CLOCK_SYNTH_DIVIDER_PLANNER_CORE_DEFINES_SVH
`define CLOCK_SYNTH_DIVIDER_PLANNER_CORE_DEFINES_SVH
`ifndef SYNTHESIS
// checked outside reset
`define CSDP_ASSERT(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("csdp assertion failed");
// checked on every edge, reset included
`define CSDP_ASSERT_ALWAYS(lbl, prop) \
   lbl: assert property (@(posedge clock) prop) \
      else $error("csdp assertion failed");
`else
`define CSDP_ASSERT(lbl, prop)
`define CSDP_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

/* rtl/csdp_pkg.sv */
// -----------------------------------------------------------------------------
// Clock synthesizer divider planner - package
// Shared types, codes and defaults.
// -----------------------------------------------------------------------------
package csdp_pkg;

   localparam int CSDP_FREQ_BITS = 32;
   localparam logic [19:0] DEN_LIMIT = 20'd1048575;

   // result status codes
   localparam logic [2:0] STAT_OK        = 3'd0;
   localparam logic [2:0] STAT_ZERO_ARG  = 3'd1;
   localparam logic [2:0] STAT_NO_VCO    = 3'd2;
   localparam logic [2:0] STAT_DIV_RANGE = 3'd3;
   localparam logic [2:0] STAT_INT_RANGE = 3'd4;
   localparam logic [2:0] STAT_DEN_LARGE = 3'd5;

   // register indexes
   localparam logic [2:0] REG_REF_FREQ = 3'd0;
   localparam logic [2:0] REG_VCO_MIN  = 3'd1;
   localparam logic [2:0] REG_VCO_MAX  = 3'd2;
   localparam logic [2:0] REG_ODIV_MIN = 3'd3;
   localparam logic [2:0] REG_ODIV_MAX = 3'd4;
   localparam logic [2:0] REG_PINT_MIN = 3'd5;
   localparam logic [2:0] REG_PINT_MAX = 3'd6;

   localparam logic [31:0] RST_REF_FREQ = 32'd25000000;
   localparam logic [31:0] RST_VCO_MIN  = 32'd600000000;
   localparam logic [31:0] RST_VCO_MAX  = 32'd900000000;
   localparam logic [11:0] RST_ODIV_MIN = 12'd8;
   localparam logic [11:0] RST_ODIV_MAX = 12'd2048;
   localparam logic [7:0]  RST_PINT_MIN = 8'd15;
   localparam logic [7:0]  RST_PINT_MAX = 8'd90;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DIV_LO,
      ST_DIV_HI,
      ST_CLAMP,
      ST_MUL,
      ST_DIV_A,
      ST_GCD,
      ST_GCD_WAIT,
      ST_RED_B,
      ST_RED_C,
      ST_DONE
   } csdp_state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } csdp_div_stat_type;

   // keeps the low 'bits' bits of a 32-bit frequency word
   function automatic logic [31:0] csdp_freq_mask(input int bits);
      logic [31:0] m;
      m = '0;
      for (int i = 0; i < 32; i++) begin
         m[i] = (i < bits);
      end
      return m;
   endfunction

endpackage

/* rtl/clock_synth_divider_planner_core.sv */
// -----------------------------------------------------------------------------
// Clock synthesizer divider planner - top level
// Plans output divider and fractional PLL ratio for a requested frequency.
// -----------------------------------------------------------------------------
// One request at a time. A request steps through the control states and makes one
// pass of the shared serial divider per division: ceil(vco_min/target),
// vco_max/target, vco/ref, one per Euclid step on the remainder and the
// reference, and two for the reduction of the fraction; a zero argument skips
// the divider. req_stall stays high until the result is parked in the output
// register, which may still wait on rsp_stall while the next request is taken.
// Configuration writes are taken every cycle (csr_ready is tied high); index 7
// is ignored.
// -----------------------------------------------------------------------------
`include "clock_synth_divider_planner_core_defines.svh"

module clock_synth_divider_planner_core #(
   parameter int FREQ_BITS = csdp_pkg::CSDP_FREQ_BITS
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_target_hz,
   // result channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_status,
   output logic [7:0]  rsp_pll_int,
   output logic [19:0] rsp_pll_num,
   output logic [19:0] rsp_pll_den,
   output logic [11:0] rsp_out_div,
   output logic [31:0] rsp_vco_hz,
   // register write port
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata
);
   import csdp_pkg::*;

   // datapath width: room for vco_min+target-1 and target*N
   localparam int DW = FREQ_BITS + 13;
   localparam logic [31:0] FREQ_MASK = csdp_freq_mask(FREQ_BITS);

   // configuration registers
   logic [31:0] ref_ff, vmin_ff, vmax_ff;
   logic [11:0] odmin_ff, odmax_ff;
   logic [7:0]  pimin_ff, pimax_ff;

   csdp_state_type state_ff, state_in;

   logic [31:0]   clk_ff, clk_in;
   logic [DW-1:0] nlo_ff, nlo_in, nhi_ff, nhi_in;
   logic [11:0]   n_ff, n_in;
   logic [DW-1:0] vco_ff, vco_in;
   logic [DW-1:0] a_ff, a_in, b_ff, b_in;
   logic [DW-1:0] x_ff, x_in, y_ff, y_in;
   logic [19:0]   c_ff, c_in;
   logic [2:0]    stat_ff, stat_in;

   // output register
   logic          rsp_valid_ff, rsp_valid_in;
   logic [2:0]    rsp_status_ff;
   logic [7:0]    rsp_pll_int_ff;
   logic [19:0]   rsp_pll_num_ff, rsp_pll_den_ff;
   logic [11:0]   rsp_out_div_ff;
   logic [31:0]   rsp_vco_hz_ff;
   logic          rsp_load;

   // shared divider
   logic              div_start;
   logic [DW-1:0]     div_dvd, div_dvs, div_quo, div_rem;
   csdp_div_stat_type div_stat;

   logic [31:0]   clk_req;
   logic [DW-1:0] clk_ext, ref_ext, lo_clamp, hi_clamp;
   logic [43:0]   prod;
   logic          req_accept;

   assign csr_ready  = 1'b1;
   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign clk_req    = req_target_hz & FREQ_MASK;
   assign clk_ext    = {{(DW-32){1'b0}}, clk_ff};
   assign ref_ext    = {{(DW-32){1'b0}}, ref_ff};
   assign prod       = clk_ff * n_ff;

   // clamp the VCO window divider range to the divider limits
   always_comb begin
      lo_clamp = nlo_ff;
      if (nlo_ff < {{(DW-12){1'b0}}, odmin_ff}) begin
         lo_clamp = {{(DW-12){1'b0}}, odmin_ff};
      end
      hi_clamp = nhi_ff;
      if (nhi_ff > {{(DW-12){1'b0}}, odmax_ff}) begin
         hi_clamp = {{(DW-12){1'b0}}, odmax_ff};
      end
   end

   csdp_divider #(
      .WIDTH(DW)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dvd),
      .divisor  (div_dvs),
      .quotient (div_quo),
      .remainder(div_rem),
      .stat     (div_stat)
   );

   // sequencer
   always_comb begin
      state_in  = state_ff;
      clk_in    = clk_ff;
      nlo_in    = nlo_ff;
      nhi_in    = nhi_ff;
      n_in      = n_ff;
      vco_in    = vco_ff;
      a_in      = a_ff;
      b_in      = b_ff;
      x_in      = x_ff;
      y_in      = y_ff;
      c_in      = c_ff;
      stat_in   = stat_ff;
      div_start = 1'b0;
      div_dvd   = '0;
      div_dvs   = '0;
      rsp_load  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               clk_in = clk_req;
               if (ref_ff == '0 || clk_req == '0) begin
                  stat_in  = STAT_ZERO_ARG;
                  state_in = ST_DONE;
               end else begin
                  // ceiling division: (vco_min + target - 1) / target
                  div_start = 1'b1;
                  div_dvd   = {{(DW-32){1'b0}}, vmin_ff} + {{(DW-32){1'b0}}, clk_req}
                              - {{(DW-1){1'b0}}, 1'b1};
                  div_dvs   = {{(DW-32){1'b0}}, clk_req};
                  state_in  = ST_DIV_LO;
               end
            end
         end
         ST_DIV_LO: begin
            if (div_stat.done) begin
               nlo_in    = div_quo;
               div_start = 1'b1;
               div_dvd   = {{(DW-32){1'b0}}, vmax_ff};
               div_dvs   = clk_ext;
               state_in  = ST_DIV_HI;
            end
         end
         ST_DIV_HI: begin
            if (div_stat.done) begin
               nhi_in   = div_quo;
               state_in = ST_CLAMP;
            end
         end
         ST_CLAMP: begin
            if (nlo_ff > nhi_ff) begin
               stat_in  = STAT_NO_VCO;
               state_in = ST_DONE;
            end else if (lo_clamp > hi_clamp) begin
               stat_in  = STAT_DIV_RANGE;
               state_in = ST_DONE;
            end else begin
               n_in     = lo_clamp[11:0];
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            vco_in    = DW'(prod);
            div_start = 1'b1;
            div_dvd   = DW'(prod);
            div_dvs   = ref_ext;
            state_in  = ST_DIV_A;
         end
         ST_DIV_A: begin
            if (div_stat.done) begin
               a_in = div_quo;
               b_in = div_rem;
               if (div_quo < {{(DW-8){1'b0}}, pimin_ff} ||
                   div_quo > {{(DW-8){1'b0}}, pimax_ff}) begin
                  stat_in  = STAT_INT_RANGE;
                  state_in = ST_DONE;
               end else begin
                  x_in     = div_rem;
                  y_in     = ref_ext;
                  state_in = ST_GCD;
               end
            end
         end
         ST_GCD: begin
            div_start = 1'b1;
            if (y_ff == '0) begin
               // x holds the gcd: reduce the numerator
               div_dvd  = b_ff;
               div_dvs  = x_ff;
               state_in = ST_RED_B;
            end else begin
               div_dvd  = x_ff;
               div_dvs  = y_ff;
               state_in = ST_GCD_WAIT;
            end
         end
         ST_GCD_WAIT: begin
            if (div_stat.done) begin
               x_in     = y_ff;
               y_in     = div_rem;
               state_in = ST_GCD;
            end
         end
         ST_RED_B: begin
            if (div_stat.done) begin
               b_in      = div_quo;
               div_start = 1'b1;
               div_dvd   = ref_ext;
               div_dvs   = x_ff;
               state_in  = ST_RED_C;
            end
         end
         ST_RED_C: begin
            if (div_stat.done) begin
               if (div_quo > {{(DW-20){1'b0}}, DEN_LIMIT}) begin
                  stat_in = STAT_DEN_LARGE;
               end else begin
                  stat_in = STAT_OK;
                  c_in    = div_quo[19:0];
               end
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      clk_ff  <= clk_in;
      nlo_ff  <= nlo_in;
      nhi_ff  <= nhi_in;
      n_ff    <= n_in;
      vco_ff  <= vco_in;
      a_ff    <= a_in;
      b_ff    <= b_in;
      x_ff    <= x_in;
      y_ff    <= y_in;
      c_ff    <= c_in;
      stat_ff <= stat_in;
      // failures report zeros in every numeric field
      if (rsp_load) begin
         rsp_status_ff <= stat_ff;
         if (stat_ff == STAT_OK) begin
            rsp_pll_int_ff <= a_ff[7:0];
            rsp_pll_num_ff <= b_ff[19:0];
            rsp_pll_den_ff <= c_ff;
            rsp_out_div_ff <= n_ff;
            rsp_vco_hz_ff  <= vco_ff[31:0];
         end else begin
            rsp_pll_int_ff <= '0;
            rsp_pll_num_ff <= '0;
            rsp_pll_den_ff <= '0;
            rsp_out_div_ff <= '0;
            rsp_vco_hz_ff  <= '0;
         end
      end
   end

   // register file
   always_ff @(posedge clock) begin
      if (reset) begin
         ref_ff   <= RST_REF_FREQ & FREQ_MASK;
         vmin_ff  <= RST_VCO_MIN & FREQ_MASK;
         vmax_ff  <= RST_VCO_MAX & FREQ_MASK;
         odmin_ff <= RST_ODIV_MIN;
         odmax_ff <= RST_ODIV_MAX;
         pimin_ff <= RST_PINT_MIN;
         pimax_ff <= RST_PINT_MAX;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_REF_FREQ: ref_ff   <= csr_wdata & FREQ_MASK;
            REG_VCO_MIN:  vmin_ff  <= csr_wdata & FREQ_MASK;
            REG_VCO_MAX:  vmax_ff  <= csr_wdata & FREQ_MASK;
            REG_ODIV_MIN: odmin_ff <= csr_wdata[11:0];
            REG_ODIV_MAX: odmax_ff <= csr_wdata[11:0];
            REG_PINT_MIN: pimin_ff <= csr_wdata[7:0];
            REG_PINT_MAX: pimax_ff <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_status  = rsp_status_ff;
   assign rsp_pll_int = rsp_pll_int_ff;
   assign rsp_pll_num = rsp_pll_num_ff;
   assign rsp_pll_den = rsp_pll_den_ff;
   assign rsp_out_div = rsp_out_div_ff;
   assign rsp_vco_hz  = rsp_vco_hz_ff;

   // divider is only started when free
   `CSDP_ASSERT(a_div_start_free, div_start |-> !div_stat.busy)
   // an accepted request leaves idle
   `CSDP_ASSERT(a_accept_busy, req_accept |=> state_ff != ST_IDLE)
   // a good result always carries a nonzero denominator
   `CSDP_ASSERT(a_ok_den, rsp_valid && rsp_status == STAT_OK |-> rsp_pll_den != '0)
   // failed results carry zero fields
   `CSDP_ASSERT(a_fail_zero,
      rsp_valid && rsp_status != STAT_OK |-> rsp_out_div == '0 && rsp_vco_hz == '0)
   // no result is ever presented during reset
   `CSDP_ASSERT_ALWAYS(a_reset_quiet, reset |=> !rsp_valid)

endmodule

/* rtl/csdp_divider.sv */
// -----------------------------------------------------------------------------
// Clock synthesizer divider planner - serial divider
// Restoring divider, one quotient bit per cycle.
// -----------------------------------------------------------------------------
module csdp_divider #(
   parameter int WIDTH = 45
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [WIDTH-1:0]            dividend,
   input  logic [WIDTH-1:0]            divisor,
   output logic [WIDTH-1:0]            quotient,
   output logic [WIDTH-1:0]            remainder,
   output csdp_pkg::csdp_div_stat_type stat
);
   import csdp_pkg::*;

   localparam int CW = $clog2(WIDTH);

   logic            busy_ff, busy_in;
   logic            done_ff, done_in;
   logic [CW-1:0]   cnt_ff, cnt_in;
   logic [WIDTH:0]  rem_ff, rem_in;
   logic [WIDTH-1:0] quo_ff, quo_in;
   logic [WIDTH-1:0] dvs_ff, dvs_in;
   logic [WIDTH:0]  rem_sh;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      rem_sh  = {rem_ff[WIDTH-1:0], quo_ff[WIDTH-1]};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         if (rem_sh >= {1'b0, dvs_ff}) begin
            rem_in = rem_sh - {1'b0, dvs_ff};
            quo_in = {quo_ff[WIDTH-2:0], 1'b1};
         end else begin
            rem_in = rem_sh;
            quo_in = {quo_ff[WIDTH-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CW'(WIDTH - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign quotient  = quo_ff;
   assign remainder = rem_ff[WIDTH-1:0];
   assign stat.busy = busy_ff;
   assign stat.done = done_ff;

endmodule

/* verif/clock_synth_divider_planner_core_checker.sv */
`timescale 1ns / 100ps
// -----------------------------------------------------------------------------
// Divider planner checker
// Tracks register writes, predicts one plan per accepted request and checks
// every accepted response against the oldest pending plan.
// -----------------------------------------------------------------------------
module clock_synth_divider_planner_core_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [31:0] req_target_hz,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [2:0]  rsp_status,
   input  logic [7:0]  rsp_pll_int,
   input  logic [19:0] rsp_pll_num,
   input  logic [19:0] rsp_pll_den,
   input  logic [11:0] rsp_out_div,
   input  logic [31:0] rsp_vco_hz,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata,
   output int          fail_count,
   output int          pending_count
);
   import csdp_pkg::*;

   typedef struct packed {
      logic [2:0]  status;
      logic [7:0]  pll_int;
      logic [19:0] pll_num;
      logic [19:0] pll_den;
      logic [11:0] out_div;
      logic [31:0] vco_hz;
   } plan_type;

   logic [31:0] ref_freq, vco_min, vco_max;
   logic [11:0] odiv_min, odiv_max;
   logic [7:0]  pint_min, pint_max;
   plan_type    plan_queue[$];

   function automatic plan_type plan_divider(input logic [31:0] target);
      plan_type p;
      longint unsigned clk, xtal, n_lo, n_hi, vco, a, b, c, x, y, t;
      p = '0;
      clk = target;
      xtal = ref_freq;
      if (xtal == 0 || clk == 0) begin
         p.status = STAT_ZERO_ARG;
         return p;
      end
      n_lo = (vco_min + clk - 1) / clk;
      n_hi = vco_max / clk;
      if (n_lo > n_hi) begin
         p.status = STAT_NO_VCO;
         return p;
      end
      if (n_lo < odiv_min) n_lo = odiv_min;
      if (n_hi > odiv_max) n_hi = odiv_max;
      if (n_lo > n_hi) begin
         p.status = STAT_DIV_RANGE;
         return p;
      end
      vco = clk * n_lo;
      a = vco / xtal;
      b = vco % xtal;
      if (a < pint_min || a > pint_max) begin
         p.status = STAT_INT_RANGE;
         return p;
      end
      // Euclid on remainder and reference; 0/c reduces to 0/1
      x = b;
      y = xtal;
      while (y != 0) begin
         t = x % y;
         x = y;
         y = t;
      end
      c = xtal / x;
      b = b / x;
      if (c > DEN_LIMIT) begin
         p.status = STAT_DEN_LARGE;
         return p;
      end
      p.status  = STAT_OK;
      p.pll_int = a[7:0];
      p.pll_num = b[19:0];
      p.pll_den = c[19:0];
      p.out_div = n_lo[11:0];
      p.vco_hz  = vco[31:0];
      return p;
   endfunction

   assign pending_count = plan_queue.size();

   always @(posedge clock) begin
      plan_type want, got;
      if (reset) begin
         ref_freq <= RST_REF_FREQ;
         vco_min  <= RST_VCO_MIN;
         vco_max  <= RST_VCO_MAX;
         odiv_min <= RST_ODIV_MIN;
         odiv_max <= RST_ODIV_MAX;
         pint_min <= RST_PINT_MIN;
         pint_max <= RST_PINT_MAX;
         fail_count <= 0;
         plan_queue.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_REF_FREQ: ref_freq <= csr_wdata;
               REG_VCO_MIN:  vco_min  <= csr_wdata;
               REG_VCO_MAX:  vco_max  <= csr_wdata;
               REG_ODIV_MIN: odiv_min <= csr_wdata[11:0];
               REG_ODIV_MAX: odiv_max <= csr_wdata[11:0];
               REG_PINT_MIN: pint_min <= csr_wdata[7:0];
               REG_PINT_MAX: pint_max <= csr_wdata[7:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall)
            plan_queue.push_back(plan_divider(req_target_hz));
         if (rsp_valid && !rsp_stall) begin
            got = {rsp_status, rsp_pll_int, rsp_pll_num, rsp_pll_den, rsp_out_div,
                   rsp_vco_hz};
            if (plan_queue.size() == 0) begin
               fail_count <= fail_count + 1;
               if (fail_count < 10)
                  $display("unexpected response: %p", got);
            end else begin
               want = plan_queue.pop_front();
               if (got !== want) begin
                  fail_count <= fail_count + 1;
                  if (fail_count < 10)
                     $display("mismatch: expected %p, got %p", want, got);
               end
            end
         end
      end
   end

endmodule

/* verif/clock_synth_divider_planner_core_test.sv */
`timescale 1ns / 100ps
// -----------------------------------------------------------------------------
// Divider planner testbench
// Drives directed and random frequency requests through several register
// settings, with random idling on both channels and one long response hold.
// -----------------------------------------------------------------------------
module clock_synth_divider_planner_core_test;
   import csdp_pkg::*;

   // watchdog limit and length of the long response hold
   localparam int IDLE_LIMIT = 20000;
   localparam int LONG_HOLD  = 4000;

   logic        clock, reset;
   logic        req_valid, req_stall;
   logic [31:0] req_target_hz;
   logic        rsp_valid, rsp_stall;
   logic [2:0]  rsp_status;
   logic [7:0]  rsp_pll_int;
   logic [19:0] rsp_pll_num, rsp_pll_den;
   logic [11:0] rsp_out_div;
   logic [31:0] rsp_vco_hz;
   logic        csr_valid, csr_ready;
   logic [2:0]  csr_index;
   logic [31:0] csr_wdata;
   int          fail_count, pending_count;
   int          rsp_taken;

   clock_synth_divider_planner_core dut (.*);
   clock_synth_divider_planner_core_checker checker_i (.*);

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Watchdog: any handshake on any channel resets the count.
   initial begin
      int quiet;
      quiet = 0;
      forever begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
             (csr_valid && csr_ready) || reset)
            quiet = 0;
         else
            quiet++;
         if (quiet >= IDLE_LIMIT) begin
            $display("simulation failed");
            $finish;
         end
      end
   end

   // Response side: random stalls, bursts without stalls, and one long hold
   // so requests back up and req_stall is exercised.
   initial begin
      int gap;
      rsp_stall <= 1'b1;
      rsp_taken = 0;
      @(negedge reset);
      forever begin
         gap = $urandom_range(0, 5);
         if ((rsp_taken / 25) % 3 == 1) gap = 0;
         if (rsp_taken == 60) gap = LONG_HOLD;
         if (gap > 0) begin
            rsp_stall <= 1'b1;
            repeat (gap) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
         rsp_taken++;
      end
   end

   task automatic send_request(input logic [31:0] target);
      int gap;
      gap = $urandom_range(0, 5);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_target_hz <= target;
      do @(posedge clock); while (req_stall);
   endtask

   // csr_valid stays up across back-to-back writes; caller lowers it
   task automatic write_reg(input logic [2:0] index, input logic [31:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic load_regs(input logic [31:0] ref_hz, vmin, vmax,
                            input logic [11:0] dmin, dmax,
                            input logic [7:0] imin, imax);
      write_reg(REG_REF_FREQ, ref_hz);
      write_reg(REG_VCO_MIN, vmin);
      write_reg(REG_VCO_MAX, vmax);
      write_reg(REG_ODIV_MIN, {20'h0, dmin});
      write_reg(REG_ODIV_MAX, {20'h0, dmax});
      write_reg(REG_PINT_MIN, {24'h0, imin});
      write_reg(REG_PINT_MAX, {24'h0, imax});
      csr_valid <= 1'b0;
   endtask

   // block must be idle before touching registers
   task automatic drain;
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      @(posedge clock);
   endtask

   // mostly plausible targets, some tiny, some full range
   task automatic send_random(input int count);
      int pick;
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 70)
            send_request($urandom_range(200_000, 150_000_000));
         else if (pick < 85)
            send_request($urandom_range(0, 1000));
         else
            send_request($urandom);
      end
   endtask

   initial begin
      reset         <= 1'b1;
      req_valid     <= 1'b0;
      req_target_hz <= '0;
      csr_valid     <= 1'b0;
      csr_index     <= '0;
      csr_wdata     <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed, reset register values
      send_request(32'd0);            // zero argument
      send_request(32'd1);            // divider far above limit
      send_request(32'hFFFF_FFFF);    // no divider fits window
      send_request(32'd950_000_000);  // no divider fits window
      send_request(32'd1000);         // divider above out_div_max
      send_request(32'd10_000_000);   // exact multiple, fraction 0/1
      send_request(32'd100_000_000);  // clamped up to out_div_min
      send_request(32'd12_345_678);
      send_request(32'd75_000_000);
      send_request(32'd600_000_000);
      send_request(32'd900_000_000);
      send_request(32'd50_000_001);
      send_random(20);
      drain();

      // Wide limits at the extremes
      load_regs(32'd27_000_000, 32'd400_000_000, 32'd1_000_000_000,
                12'd1, 12'd4095, 8'd0, 8'd255);
      send_random(116);
      drain();

      // Zero divider allowed, zero VCO floor, full VCO ceiling
      load_regs(32'd1_048_583, 32'd0, 32'hFFFF_FFFF, 12'd0, 12'd4095, 8'd0, 8'd255);
      write_reg(3'd7, 32'hFFFF_FFFF); // unmapped index, ignored
      csr_valid <= 1'b0;
      send_random(30);
      drain();

      // Prime reference: denominators rarely reduce below the limit
      load_regs(32'd1_048_583, 32'd100_000_000, 32'd200_000_000,
                12'd1, 12'd4095, 8'd0, 8'd255);
      send_request(32'd1_048_583);
      send_random(60);
      drain();

      // Limits inverted, all-ones reference and VCO floor
      load_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0, 12'd4095, 12'd1, 8'd255, 8'd0);
      send_random(20);
      drain();

      // Inverted PLL integer limits only, first with a zero reference
      load_regs(32'd0, RST_VCO_MIN, RST_VCO_MAX, RST_ODIV_MIN, RST_ODIV_MAX,
                8'd40, 8'd30);
      send_request(32'd10_000_000);   // zero reference
      drain();
      load_regs(RST_REF_FREQ, RST_VCO_MIN, RST_VCO_MAX, RST_ODIV_MIN, RST_ODIV_MAX,
                8'd40, 8'd30);
      send_random(40);
      drain();

      repeat (50) @(posedge clock);
      if (fail_count == 0 && pending_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
